@@ rtl/csq_pkg.sv @@
// Shared types and constants for the counting semaphore unit.
// No dependencies; used by the channel interfaces and the top level.
package csq_pkg;

  localparam int ID_W    = 4;
  localparam int PID_W   = 8;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    CSQ_CREATE = 2'd0,
    CSQ_LOCK   = 2'd1,
    CSQ_UNLOCK = 2'd2
  } csq_func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_QFULL  = 2'd2,
    ST_SAT    = 2'd3
  } csq_status_t;

  typedef struct packed {
    csq_func_t          func;
    logic [ID_W-1:0]    sem_id;
    logic [PID_W-1:0]   caller_pid;
    logic [COUNT_W-1:0] init_count;
  } csq_req_t;

  typedef struct packed {
    logic [ID_W-1:0]  new_sem_id;
    logic             blocked;
    logic             woke_valid;
    logic [PID_W-1:0] woke_pid;
    csq_status_t      status;
  } csq_rsp_t;

endpackage

@@ rtl/csq_ifs.sv @@
// Valid/ready channel interfaces for semaphore requests and results.
// Depends on csq_pkg for the payload types.
interface csq_req_if;
  logic              valid;
  logic              ready;
  csq_pkg::csq_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csq_rsp_if;
  logic              valid;
  logic              ready;
  csq_pkg::csq_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/counting_semaphore_wait_queues_unit.sv @@
// Counting semaphore unit with a FIFO wait queue per semaphore.
// Depends on csq_pkg and the channel interfaces in csq_ifs.sv.
//
// One request is worked at a time: a request passes through accept, per-semaphore record read
// and execute, and through a further pop step when an unlock wakes a waiter, since the
// wait-queue memory then needs its own registered read. The result sits in an output
// register, so the next request is accepted while it waits to be taken; execution stalls
// only if the previous result is still pending. The semaphore record memory (count, queue
// head, queue length) has one valid bit per semaphore, so no clearing pass follows reset.
module counting_semaphore_wait_queues_unit #(
  parameter int NUM_SEMS   = 16,
  parameter int WAIT_DEPTH = 16,
  parameter int PID_BITS   = 8
) (
  input logic       clk,
  input logic       rst,
  csq_req_if.sink   req,
  csq_rsp_if.source rsp
);

  localparam int SW = $clog2(NUM_SEMS);
  localparam int FW = $clog2(NUM_SEMS + 1);
  localparam int QW = $clog2(WAIT_DEPTH);
  localparam int LW = $clog2(WAIT_DEPTH + 1);
  localparam int PW = (PID_BITS < csq_pkg::PID_W) ? PID_BITS : csq_pkg::PID_W;
  localparam int QA = SW + QW;
  localparam int CW = csq_pkg::COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EXEC = 4'b0100,
    S_POP  = 4'b1000
  } state_t;

  state_t state, state_next;
  csq_pkg::csq_req_t cur;
  csq_pkg::csq_rsp_t res;

  logic [SW-1:0] sid;
  logic          sid_ok;

  logic [NUM_SEMS-1:0] rec_vld;
  logic [CW-1:0]       cnt_mem  [NUM_SEMS];
  logic [QW-1:0]       head_mem [NUM_SEMS];
  logic [LW-1:0]       len_mem  [NUM_SEMS];
  logic [PW-1:0]       wq_mem   [2**QA];

  logic [CW-1:0] cnt_rd;
  logic [QW-1:0] head_rd;
  logic [LW-1:0] len_rd;
  logic          vld_rd;
  logic [PW-1:0] wq_rd;

  logic [CW-1:0] cnt_cur;
  logic [QW-1:0] head_cur, head_nx, slot;
  logic [LW-1:0] len_cur;
  logic [QW:0]   slot_sum;

  logic [SW-1:0] free_head;
  logic [FW-1:0] free_len;

  logic          rec_we, wq_we, wq_re, fl_take, load, slot_free;
  logic [SW-1:0] rec_waddr;
  logic [CW-1:0] cnt_wd;
  logic [QW-1:0] head_wd;
  logic [LW-1:0] len_wd;

  assign sid       = SW'(cur.sem_id);
  assign sid_ok    = 32'(cur.sem_id) < NUM_SEMS;
  assign req.ready = (state == S_IDLE);
  assign slot_free = !rsp.valid || rsp.ready;

  assign cnt_cur  = vld_rd ? cnt_rd : '0;
  assign head_cur = vld_rd ? head_rd : '0;
  assign len_cur  = vld_rd ? len_rd : '0;
  assign head_nx  = (32'(head_cur) == WAIT_DEPTH - 1) ? '0 : head_cur + QW'(1);
  assign slot_sum = {1'b0, head_cur} + (QW + 1)'(len_cur);
  assign slot     = (32'(slot_sum) >= WAIT_DEPTH) ?
                    QW'(slot_sum - (QW + 1)'(WAIT_DEPTH)) : QW'(slot_sum);

  always_comb begin
    state_next = state;
    res        = '0;
    rec_we     = 1'b0;
    rec_waddr  = sid;
    cnt_wd     = cnt_cur;
    head_wd    = head_cur;
    len_wd     = len_cur;
    wq_we      = 1'b0;
    wq_re      = 1'b0;
    fl_take    = 1'b0;
    load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_RD;
      end
      S_RD: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cur.func == csq_pkg::CSQ_UNLOCK && sid_ok && len_cur != '0) begin
          wq_re      = 1'b1;
          state_next = S_POP;
        end else if (slot_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          case (cur.func)
            csq_pkg::CSQ_CREATE: begin
              if (free_len == '0) begin
                res.status = csq_pkg::ST_NOFREE;
              end else begin
                res.new_sem_id = csq_pkg::ID_W'(free_head);
                rec_we         = 1'b1;
                rec_waddr      = free_head;
                cnt_wd         = cur.init_count;
                head_wd        = '0;
                len_wd         = '0;
                fl_take        = 1'b1;
              end
            end
            csq_pkg::CSQ_LOCK: begin
              if (sid_ok) begin
                if (cnt_cur != '0) begin
                  rec_we = 1'b1;
                  cnt_wd = cnt_cur - CW'(1);
                end else if (32'(len_cur) >= WAIT_DEPTH) begin
                  res.status = csq_pkg::ST_QFULL;
                end else begin
                  wq_we       = 1'b1;
                  rec_we      = 1'b1;
                  len_wd      = len_cur + LW'(1);
                  res.blocked = 1'b1;
                end
              end
            end
            csq_pkg::CSQ_UNLOCK: begin
              if (sid_ok) begin
                if (cnt_cur == csq_pkg::COUNT_MAX) begin
                  res.status = csq_pkg::ST_SAT;
                end else begin
                  rec_we = 1'b1;
                  cnt_wd = cnt_cur + CW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (slot_free) begin
          load           = 1'b1;
          state_next     = S_IDLE;
          rec_we         = 1'b1;
          head_wd        = head_nx;
          len_wd         = len_cur - LW'(1);
          res.woke_valid = 1'b1;
          res.woke_pid   = csq_pkg::PID_W'(wq_rd);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rec_vld   <= '0;
      free_head <= '0;
      free_len  <= FW'(NUM_SEMS);
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rec_we) rec_vld[rec_waddr] <= 1'b1;
      if (fl_take) begin
        free_head <= (32'(free_head) == NUM_SEMS - 1) ? '0 : free_head + SW'(1);
        free_len  <= free_len - FW'(1);
      end
      if (load) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) cur <= req.data;
    if (load) rsp.data <= res;
  end

  // per-semaphore record memory and wait-queue memory
  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      cnt_rd  <= cnt_mem[sid];
      head_rd <= head_mem[sid];
      len_rd  <= len_mem[sid];
      vld_rd  <= rec_vld[sid];
    end
    if (rec_we) begin
      cnt_mem[rec_waddr]  <= cnt_wd;
      head_mem[rec_waddr] <= head_wd;
      len_mem[rec_waddr]  <= len_wd;
    end
    if (wq_re) wq_rd <= wq_mem[{sid, head_cur}];
    if (wq_we) wq_mem[{sid, slot}] <= PW'(cur.caller_pid);
  end

  a_free_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(free_len) <= NUM_SEMS)
    else $error("free list length above semaphore count");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_EXEC || state == S_POP))
    else $error("result raised outside execute or pop");

  a_block_or_wake: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.blocked && rsp.data.woke_valid))
    else $error("result both blocked and woke");

  a_append_len: assert property (@(posedge clk) disable iff (rst)
    wq_we |-> (rec_we && len_wd == len_cur + LW'(1)))
    else $error("queue append without length update");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench for counting_semaphore_wait_queues_unit: directed and random semaphore requests.
// Depends on csq_pkg, csq_ifs.sv and the unit's RTL; predicts every result in a scoreboard.
module tb;
  import csq_pkg::*;

  localparam int SEMS = 16;
  localparam int DEPTH = 16;
  localparam int N_RANDOM = 1375;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  class sem_scoreboard;
    logic [COUNT_W-1:0] count [SEMS];
    logic [PID_W-1:0]   waiters [SEMS][DEPTH];
    logic [3:0]         q_head [SEMS];
    logic [4:0]         q_len [SEMS];
    logic [ID_W-1:0]    free_ids [SEMS];
    logic [3:0]         free_head;
    logic [4:0]         free_len;
    csq_rsp_t           owed[$];
    int errors, n_req, n_blocked, n_woke, n_qfull, n_sat, n_nofree, n_created;

    function new();
      for (int i = 0; i < SEMS; i++) begin
        count[i] = '0;
        q_head[i] = '0;
        q_len[i] = '0;
        free_ids[i] = ID_W'(i);
      end
      free_head = '0;
      free_len = 5'(SEMS);
    endfunction

    function csq_rsp_t apply_request(csq_req_t r);
      csq_rsp_t o;
      logic [3:0] sid, slot;
      logic [ID_W-1:0] id;
      o = '0;
      sid = r.sem_id;
      case (r.func)
        CSQ_CREATE: begin
          if (free_len == 0) begin
            o.status = ST_NOFREE;
          end else begin
            id = free_ids[free_head];
            free_head = free_head + 1'b1;
            free_len = free_len - 1'b1;
            count[id] = r.init_count;
            q_head[id] = '0;
            q_len[id] = '0;
            o.new_sem_id = id;
          end
        end
        CSQ_LOCK: begin
          if (count[sid] != 0) begin
            count[sid] = count[sid] - 1'b1;
          end else if (q_len[sid] == DEPTH) begin
            o.status = ST_QFULL;
          end else begin
            slot = q_head[sid] + q_len[sid][3:0];
            waiters[sid][slot] = r.caller_pid;
            q_len[sid] = q_len[sid] + 1'b1;
            o.blocked = 1'b1;
          end
        end
        CSQ_UNLOCK: begin
          if (q_len[sid] == 0) begin
            if (count[sid] == COUNT_MAX) o.status = ST_SAT;
            else count[sid] = count[sid] + 1'b1;
          end else begin
            o.woke_valid = 1'b1;
            o.woke_pid = waiters[sid][q_head[sid]];
            q_head[sid] = q_head[sid] + 1'b1;
            q_len[sid] = q_len[sid] - 1'b1;
          end
        end
        default: ;
      endcase
      return o;
    endfunction

    function void note_request(csq_req_t r);
      csq_rsp_t e;
      e = apply_request(r);
      owed.push_back(e);
      n_req++;
      if (e.blocked) n_blocked++;
      if (e.woke_valid) n_woke++;
      if (e.status == ST_QFULL) n_qfull++;
      if (e.status == ST_SAT) n_sat++;
      if (e.status == ST_NOFREE) n_nofree++;
      if (r.func == CSQ_CREATE && e.status == ST_OK) n_created++;
    endfunction

    function void check_result(csq_rsp_t a);
      csq_rsp_t e;
      if (owed.size() == 0) begin
        $error("result with no request outstanding: %h", a);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (a.new_sem_id !== e.new_sem_id) begin
        $error("new_sem_id: expected %0d, got %0d", e.new_sem_id, a.new_sem_id);
        errors++;
      end
      if (a.blocked !== e.blocked) begin
        $error("blocked: expected %0d, got %0d", e.blocked, a.blocked);
        errors++;
      end
      if (a.woke_valid !== e.woke_valid) begin
        $error("woke_valid: expected %0d, got %0d", e.woke_valid, a.woke_valid);
        errors++;
      end
      if (a.woke_pid !== e.woke_pid) begin
        $error("woke_pid: expected %0d, got %0d", e.woke_pid, a.woke_pid);
        errors++;
      end
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  csq_req_if req_ch();
  csq_rsp_if rsp_ch();

  counting_semaphore_wait_queues_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  sem_scoreboard sb;
  bit calm;
  int long_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL counting_semaphore_wait_queues_unit");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result-side ready: random runs and stalls, plus one long hold-off on request
  initial begin
    int stall_left, run_left;
    bit rdy;
    stall_left = 0;
    run_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (long_hold > 0) begin
        stall_left = long_hold - 1;
        long_hold = 0;
        rdy = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        rdy = 1'b1;
      end else begin
        run_left = $urandom_range(0, 12);
        stall_left = pick_gap();
        rdy = (stall_left == 0);
      end
      rsp_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
  end

  function automatic csq_req_t mk_req(logic [1:0] f, logic [3:0] sid, logic [7:0] pid,
                                      logic [15:0] init);
    csq_req_t r;
    r.func = csq_func_t'(f);
    r.sem_id = sid;
    r.caller_pid = pid;
    r.init_count = init;
    return r;
  endfunction

  task automatic send_req(input csq_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
  endtask

  // drop the last request's valid, then wait for every result
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_init();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'($urandom_range(1, 8));
      2: return 16'hffff;
      3: return 16'hfffe;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int sent, phase_no, plen, lock_pct, roll;
    logic [3:0] hot, sid;
    logic [1:0] f;
    sb = new();
    calm = 1'b0;
    long_hold = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // never-created semaphore, wake order, saturation, full queue, unused code
    send_req(mk_req(CSQ_LOCK, 4'd7, 8'h00, 16'h0000));
    send_req(mk_req(CSQ_UNLOCK, 4'd7, 8'hff, 16'hffff));
    send_req(mk_req(CSQ_UNLOCK, 4'd7, 8'h3c, 16'h0000));
    send_req(mk_req(CSQ_CREATE, 4'hf, 8'h5a, 16'hffff));
    send_req(mk_req(CSQ_UNLOCK, 4'd0, 8'ha5, 16'h1234));
    send_req(mk_req(CSQ_CREATE, 4'h0, 8'h00, 16'h0000));
    for (int i = 0; i < DEPTH + 1; i++)
      send_req(mk_req(CSQ_LOCK, 4'd1, (i == 3) ? 8'hff : 8'(i), 16'($urandom)));
    send_req(mk_req(CSQ_UNLOCK, 4'd1, 8'h00, 16'h0000));
    send_req(mk_req(FUNC_UNUSED, 4'hf, 8'hff, 16'hffff));

    sent = 0;
    phase_no = 0;
    while (sent < N_RANDOM) begin
      phase_no++;
      if (phase_no % 7 == 3) wait_drain();
      if (phase_no == 4) long_hold = 300;
      calm = ($urandom_range(0, 4) == 0);
      hot = 4'($urandom_range(0, SEMS - 1));
      plen = $urandom_range(20, 80);
      roll = $urandom_range(0, 9);
      lock_pct = (roll < 3) ? 80 : (roll < 6) ? 50 : 25;
      repeat (plen) begin
        roll = $urandom_range(0, 99);
        sid = ($urandom_range(0, 99) < 70) ? hot : 4'($urandom_range(0, SEMS - 1));
        if (roll < 3) begin
          send_req(mk_req(CSQ_CREATE, 4'($urandom), 8'($urandom), pick_init()));
          sent++;
        end else if (roll < 5) begin
          send_req(mk_req(FUNC_UNUSED, 4'($urandom), 8'($urandom), 16'($urandom)));
        end else begin
          f = ($urandom_range(0, 99) < lock_pct) ? CSQ_LOCK : CSQ_UNLOCK;
          send_req(mk_req(f, sid, 8'($urandom), 16'($urandom)));
          sent++;
        end
      end
    end
    calm = 1'b0;
    wait_drain();
    repeat (20) @(posedge clk);

    $display("Checked %0d requests: %0d creates, %0d blocked locks, %0d wakeups,",
             sb.n_req, sb.n_created, sb.n_blocked, sb.n_woke);
    $display("  %0d full-queue locks, %0d saturated unlocks, %0d creates with no free id.",
             sb.n_qfull, sb.n_sat, sb.n_nofree);
    if (sb.errors == 0) begin
      $display("PASS counting_semaphore_wait_queues_unit");
    end else begin
      $display("FAIL counting_semaphore_wait_queues_unit");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/csq_pkg.sv
rtl/csq_ifs.sv
rtl/counting_semaphore_wait_queues_unit.sv
test/tb.sv
